// ----- src/uart_command_frame_receiver_core_assert.svh -----
// Assertion macros used by the back-end RTL file, ucfr_back.sv.
// Each property macro takes a label, a clock, an active-low reset and its terms.
`ifndef UART_COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`define UART_COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UCFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ucfr same-cycle assertion failed");
`define UCFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ucfr next-cycle assertion failed");
`else
`define UCFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UCFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/ucfr_pkg.sv -----
// Package of the UART command frame receiver: types, command codes and defaults.
// No dependencies; every RTL module imports it.
`default_nettype none
package ucfr_pkg;

    localparam int DEF_PARAM_WORDS = 14;
    localparam int DEF_FRAME_BYTES = 56;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_STOP     = 8'h30;
    localparam logic [7:0] CMD_TELE     = 8'h31;
    localparam logic [7:0] CMD_PARAMS   = 8'h32;
    localparam logic [7:0] CMD_FRAME    = 8'h33;
    localparam logic [7:0] CMD_EEPROM   = 8'h34;
    localparam logic [7:0] CMD_LOG      = 8'h35;
    localparam logic [7:0] CMD_BLK_ZERO = 8'h36;
    localparam logic [7:0] CMD_BLK_DEC  = 8'h37;
    localparam logic [7:0] CMD_BLK_INC  = 8'h38;
    localparam logic [7:0] CMD_BLK_LOAD = 8'h39;
    localparam logic [7:0] TAIL_BYTE    = 8'hAB;

    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_PARAMS = 2'd1;
    localparam logic [1:0] REQ_EEPROM = 2'd2;
    localparam logic [1:0] REQ_BLOCK  = 2'd3;

    typedef struct packed {
        logic        beep;
        logic        stop;
        logic        tele;
        logic [1:0]  req;
        logic        sd_save;
        logic        write_info;
        logic [15:0] block;
    } t_status;

    typedef struct packed {
        logic    frame;
        t_status st;
    } t_job;

endpackage
`default_nettype wire

// ----- src/ucfr_front.sv -----
// Front end: accepts received bytes, decodes commands, keeps the flags and block
// number, writes frame bytes to the store and queues one job per byte. Uses ucfr_pkg.
`default_nettype none
module ucfr_front import ucfr_pkg::*; #(
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    localparam int MEM_DEPTH = (FRAME_BYTES + 3) / 4,
    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1,
    localparam int CNT_W = $clog2(FRAME_BYTES + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_card_ready,
    output logic                   o_push,
    output t_job                   o_job,
    input  wire logic              i_q_full,
    input  wire logic              i_frame_done,
    output logic                   o_wr_en,
    output logic [MEM_AW-1:0]      o_wr_addr,
    output logic [1:0]             o_wr_lane,
    output logic [7:0]             o_wr_data
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'b001,
        M_FRAME = 3'b010,
        M_INDEX = 3'b100
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_low, n_low;
    logic             r_stop, n_stop;
    logic             r_tele, n_tele;
    logic             r_log, n_log;
    logic             r_winfo, n_winfo;
    logic [15:0]      r_block, n_block;
    logic             r_busy;
    logic             accept;
    logic             beep;
    logic [1:0]       req;
    logic             frame;
    logic             store_wr;

    assign o_in_ready = !i_q_full && !r_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_low    = r_low;
        n_stop   = r_stop;
        n_tele   = r_tele;
        n_log    = r_log;
        n_winfo  = r_winfo;
        n_block  = r_block;
        beep     = 1'b0;
        req      = REQ_NONE;
        frame    = 1'b0;
        store_wr = 1'b0;
        unique case (r_mode)
            M_FRAME: begin
                if (r_count < CNT_W'(FRAME_BYTES)) begin
                    store_wr = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    n_count = '0;
                    n_mode  = M_IDLE;
                    if (i_rx_byte == TAIL_BYTE) begin
                        frame = 1'b1;
                        req   = REQ_PARAMS;
                    end
                end
            end
            M_INDEX: begin
                if (r_count == '0) begin
                    n_low   = i_rx_byte;
                    n_count = CNT_W'(1);
                end else begin
                    n_block = {i_rx_byte, r_low};
                    req     = REQ_BLOCK;
                    n_count = '0;
                    n_mode  = M_IDLE;
                end
            end
            default: begin
                n_mode = M_IDLE;
                beep   = 1'b1;
                unique case (i_rx_byte)
                    CMD_STOP:   n_stop = !r_stop;
                    CMD_TELE:   n_tele = !r_tele;
                    CMD_PARAMS: req = REQ_PARAMS;
                    CMD_FRAME: begin
                        n_mode  = M_FRAME;
                        n_count = '0;
                    end
                    CMD_EEPROM: req = REQ_EEPROM;
                    CMD_LOG: begin
                        if (!r_log) begin
                            n_log   = 1'b1;
                            n_block = '0;
                            n_winfo = 1'b0;
                        end else begin
                            n_log   = 1'b0;
                            n_winfo = 1'b1;
                        end
                    end
                    CMD_BLK_ZERO: begin
                        n_block = '0;
                        req     = REQ_BLOCK;
                    end
                    CMD_BLK_DEC: begin
                        beep = 1'b0;
                        if (i_card_ready) begin
                            n_block = r_block - 16'd1;
                            req     = REQ_BLOCK;
                        end
                    end
                    CMD_BLK_INC: begin
                        beep = 1'b0;
                        if (i_card_ready) begin
                            n_block = r_block + 16'd1;
                            req     = REQ_BLOCK;
                        end
                    end
                    CMD_BLK_LOAD: begin
                        n_mode  = M_INDEX;
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_count <= '0;
            r_stop  <= 1'b0;
            r_tele  <= 1'b0;
            r_log   <= 1'b0;
            r_winfo <= 1'b0;
            r_block <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_stop  <= n_stop;
                r_tele  <= n_tele;
                r_log   <= n_log;
                r_winfo <= n_winfo;
                r_block <= n_block;
            end
            if (accept && frame) begin
                r_busy <= 1'b1;
            end else if (i_frame_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_low <= n_low;
        end
    end

    always_comb begin
        o_job.frame         = frame;
        o_job.st.beep       = beep;
        o_job.st.stop       = n_stop;
        o_job.st.tele       = n_tele;
        o_job.st.req        = req;
        o_job.st.sd_save    = n_log;
        o_job.st.write_info = n_winfo;
        o_job.st.block      = n_block;
    end

    assign o_push    = accept;
    assign o_wr_en   = accept && store_wr;
    assign o_wr_addr = MEM_AW'(r_count >> 2);
    assign o_wr_lane = r_count[1:0];
    assign o_wr_data = i_rx_byte;

endmodule
`default_nettype wire

// ----- src/ucfr_queue.sv -----
// Short job queue between the front end and the back end.
// Holds t_job entries from ucfr_pkg.
`default_nettype none
module ucfr_queue import ucfr_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    t_job          r_data [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- src/ucfr_back.sv -----
// Back end: takes jobs from the queue, holds the frame store and drives the result
// register, one status result or one parameter word at a time. Uses ucfr_pkg.
`default_nettype none
`include "uart_command_frame_receiver_core_assert.svh"
module ucfr_back import ucfr_pkg::*; #(
    parameter int PARAM_WORDS = DEF_PARAM_WORDS,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    localparam int MEM_DEPTH = (FRAME_BYTES + 3) / 4,
    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire t_job              i_job,
    output logic                   o_pop,
    input  wire logic              i_wr_en,
    input  wire logic [MEM_AW-1:0] i_wr_addr,
    input  wire logic [1:0]        i_wr_lane,
    input  wire logic [7:0]        i_wr_data,
    output logic                   o_done,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_status                o_st,
    output logic                   o_param_valid,
    output logic [3:0]             o_param_index,
    output logic [31:0]            o_param_value,
    output logic                   o_last
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_WORD  = 3'b100
    } t_bstate;

    localparam logic [3:0] LAST_IDX = 4'(PARAM_WORDS - 1);

    t_bstate          r_state, n_state;
    logic [3:0]       r_word;
    t_status          r_fst;
    logic [31:0]      r_mem [MEM_DEPTH];
    logic [31:0]      r_mem_q;
    logic [MEM_AW-1:0] rd_addr;
    logic [31:0]      word_val;
    logic             slot_free;
    logic             emit_word;
    logic             last_word;
    logic             r_ovalid;
    t_status          r_ost;
    logic             r_opvalid;
    logic [3:0]       r_oidx;
    logic [31:0]      r_oval;
    logic             r_olast;

    assign slot_free = !r_ovalid || i_out_ready;
    assign o_pop     = (r_state == B_IDLE) && !i_empty && (i_job.frame || slot_free);
    assign emit_word = (r_state == B_WORD) && slot_free;
    assign last_word = (r_word == LAST_IDX);
    assign o_done    = emit_word && last_word;
    assign rd_addr   = ({1'b0, r_word} < 5'(MEM_DEPTH)) ? MEM_AW'(r_word) : '0;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            word_val[8*k +: 8] = ({1'b0, r_word, 2'(k)} < 7'(FRAME_BYTES)) ?
                                 r_mem_q[8*k +: 8] : 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (o_pop && i_job.frame) begin
                    n_state = B_FETCH;
                end
            end
            B_FETCH: n_state = B_WORD;
            B_WORD: begin
                if (emit_word) begin
                    n_state = last_word ? B_IDLE : B_FETCH;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((o_pop && !i_job.frame) || emit_word) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.frame) begin
            r_word <= '0;
            r_fst  <= i_job.st;
        end else if (emit_word && !last_word) begin
            r_word <= r_word + 4'd1;
        end
        if (o_pop && !i_job.frame) begin
            r_ost     <= i_job.st;
            r_opvalid <= 1'b0;
            r_oidx    <= '0;
            r_oval    <= '0;
            r_olast   <= 1'b1;
        end else if (emit_word) begin
            r_ost     <= r_fst;
            r_opvalid <= 1'b1;
            r_oidx    <= r_word;
            r_oval    <= word_val;
            r_olast   <= last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    assign o_out_valid   = r_ovalid;
    assign o_st          = r_ost;
    assign o_param_valid = r_opvalid;
    assign o_param_index = r_oidx;
    assign o_param_value = r_oval;
    assign o_last        = r_olast;

    `UCFR_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_empty)
    `UCFR_ASSERT_IMP(a_done_last_word, i_clk, i_rst_n, o_done, r_word == LAST_IDX)
    `UCFR_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, o_done, r_state == B_IDLE)
    `UCFR_ASSERT_IMP(a_index_range, i_clk, i_rst_n, r_ovalid && r_opvalid, r_oidx <= LAST_IDX)

endmodule
`default_nettype wire

// ----- src/uart_command_frame_receiver_core.sv -----
// A plain byte passes the job queue and the output register; one byte per cycle while the
// output is not held back and no frame is read out. A 0xAB tail gives its words one by one,
// paced by the registered read of the frame store; input stalls until the last word is out.
// Reset is synchronous, active low: flags, mode, block number and queue clear at once,
// and the frame store is not cleared.
`default_nettype none
module uart_command_frame_receiver_core import ucfr_pkg::*; #(
    parameter int PARAM_WORDS = DEF_PARAM_WORDS,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int MEM_DEPTH = (FRAME_BYTES + 3) / 4,
    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_card_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_beep_pulse,
    output logic             o_stop_control,
    output logic             o_send_data_control,
    output logic [1:0]       o_request,
    output logic             o_sd_save,
    output logic             o_sd_write_info,
    output logic [15:0]      o_block_number,
    output logic             o_param_valid,
    output logic [3:0]       o_param_index,
    output logic [31:0]      o_param_value,
    output logic             o_last
);

    logic              q_push, q_pop, q_full, q_empty;
    t_job              push_job, pop_job;
    logic              frame_done;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [1:0]        wr_lane;
    logic [7:0]        wr_data;
    t_status           out_st;

    ucfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_card_ready (i_card_ready),
        .o_push       (q_push),
        .o_job        (push_job),
        .i_q_full     (q_full),
        .i_frame_done (frame_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_lane    (wr_lane),
        .o_wr_data    (wr_data)
    );

    ucfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (pop_job),
        .o_empty (q_empty)
    );

    ucfr_back #(
        .PARAM_WORDS (PARAM_WORDS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_job         (pop_job),
        .o_pop         (q_pop),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_lane     (wr_lane),
        .i_wr_data     (wr_data),
        .o_done        (frame_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_st          (out_st),
        .o_param_valid (o_param_valid),
        .o_param_index (o_param_index),
        .o_param_value (o_param_value),
        .o_last        (o_last)
    );

    assign o_beep_pulse        = out_st.beep;
    assign o_stop_control      = out_st.stop;
    assign o_send_data_control = out_st.tele;
    assign o_request           = out_st.req;
    assign o_sd_save           = out_st.sd_save;
    assign o_sd_write_info     = out_st.write_info;
    assign o_block_number      = out_st.block;

endmodule
`default_nettype wire

// ----- sim/uart_command_frame_receiver_core_tb.sv -----
// Self-checking testbench for uart_command_frame_receiver_core: directed command rows, then
// random command, index and parameter-frame sequences, scored against a behavioral predictor.
// Depends on ucfr_pkg and the receiver RTL only.
`default_nettype none
module uart_command_frame_receiver_core_tb import ucfr_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PARAM_WORDS = DEF_PARAM_WORDS;
    localparam int FRAME_LEN = DEF_FRAME_BYTES;
    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED = 26;

    typedef enum logic [1:0] {RX_IDLE, RX_FRAME, RX_INDEX} t_rx_mode;

    typedef struct packed {
        t_status     st;
        logic        pvalid;
        logic [3:0]  pidx;
        logic [31:0] pval;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0]  rx;
        logic        rdy;
        logic        typed;
        logic        beep;
        logic        stop;
        logic        tele;
        logic [1:0]  req;
        logic        sd;
        logic        wi;
        logic [15:0] blk;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00,        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{8'hFF,        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_STOP,     1'b0, 1'b1, 1'b1, 1'b1, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_TELE,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_PARAMS,   1'b0, 1'b1, 1'b1, 1'b1, 1'b1, REQ_PARAMS, 1'b0, 1'b0, 16'h0000},
        '{CMD_PARAMS,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1, REQ_PARAMS, 1'b0, 1'b0, 16'h0000},
        '{CMD_EEPROM,   1'b0, 1'b1, 1'b1, 1'b1, 1'b1, REQ_EEPROM, 1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_DEC,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_DEC,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, REQ_BLOCK,  1'b0, 1'b0, 16'hFFFF},
        '{CMD_BLK_INC,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, REQ_BLOCK,  1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_INC,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_DEC,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, REQ_BLOCK,  1'b0, 1'b0, 16'hFFFF},
        '{CMD_LOG,      1'b0, 1'b1, 1'b1, 1'b1, 1'b1, REQ_NONE,   1'b1, 1'b0, 16'h0000},
        '{CMD_BLK_LOAD, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, REQ_NONE,   1'b1, 1'b0, 16'h0000},
        '{8'hFF,        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, REQ_NONE,   1'b1, 1'b0, 16'h0000},
        '{8'hFF,        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, REQ_BLOCK,  1'b1, 1'b0, 16'hFFFF},
        '{CMD_BLK_INC,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, REQ_BLOCK,  1'b1, 1'b0, 16'h0000},
        '{CMD_BLK_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{8'h34,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{8'h12,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_LOG,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_LOG,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_INC,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REQ_NONE,   1'b0, 1'b0, 16'h0000},
        '{CMD_BLK_ZERO, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, REQ_BLOCK,  1'b1, 1'b0, 16'h0000},
        '{CMD_STOP,     1'b1, 1'b1, 1'b1, 1'b0, 1'b1, REQ_NONE,   1'b1, 1'b0, 16'h0000},
        '{CMD_TELE,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0, REQ_NONE,   1'b1, 1'b0, 16'h0000}
    };

    localparam logic [7:0] COMMANDS [10] = '{
        CMD_STOP, CMD_TELE, CMD_PARAMS, CMD_FRAME, CMD_EEPROM,
        CMD_LOG, CMD_BLK_ZERO, CMD_BLK_DEC, CMD_BLK_INC, CMD_BLK_LOAD
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_card_ready = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_beep_pulse;
    logic        o_stop_control;
    logic        o_send_data_control;
    logic [1:0]  o_request;
    logic        o_sd_save;
    logic        o_sd_write_info;
    logic [15:0] o_block_number;
    logic        o_param_valid;
    logic [3:0]  o_param_index;
    logic [31:0] o_param_value;
    logic        o_last;

    t_rx_mode    mode_now = RX_IDLE;
    int          frame_fill = 0;
    logic [7:0]  frame_bytes [64];
    logic [7:0]  index_low = 8'h00;
    logic        stop_state = 1'b0;
    logic        tele_state = 1'b0;
    logic        log_state = 1'b0;
    logic        winfo_state = 1'b0;
    logic [15:0] block_state = 16'h0000;

    t_result     awaited_results [$];
    t_result     got_res;
    t_result     want_res;
    bit          calm = 1'b0;
    int          sink_hold = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          good_tails = 0;
    int          bad_tails = 0;

    uart_command_frame_receiver_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_rx_byte          (i_rx_byte),
        .i_card_ready       (i_card_ready),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_beep_pulse       (o_beep_pulse),
        .o_stop_control     (o_stop_control),
        .o_send_data_control(o_send_data_control),
        .o_request          (o_request),
        .o_sd_save          (o_sd_save),
        .o_sd_write_info    (o_sd_write_info),
        .o_block_number     (o_block_number),
        .o_param_valid      (o_param_valid),
        .o_param_index      (o_param_index),
        .o_param_value      (o_param_value),
        .o_last             (o_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_status status_after(input logic beep, input logic [1:0] req);
        return '{beep: beep, stop: stop_state, tele: tele_state, req: req,
                 sd_save: log_state, write_info: winfo_state, block: block_state};
    endfunction

    function automatic void decode_rx_byte(input logic [7:0] b, input logic rdy);
        logic        beep;
        logic [1:0]  req;
        logic [31:0] word;
        beep = 1'b0;
        req = REQ_NONE;
        case (mode_now)
            RX_FRAME: begin
                if (frame_fill < FRAME_LEN) begin
                    frame_bytes[frame_fill] = b;
                    frame_fill++;
                end else begin
                    frame_fill = 0;
                    mode_now = RX_IDLE;
                    if (b == TAIL_BYTE) begin
                        good_tails++;
                        for (int w = 0; w < PARAM_WORDS; w++) begin
                            word = '0;
                            for (int i = 3; i >= 0; i--) begin
                                word = {word[23:0],
                                        (4 * w + i < FRAME_LEN) ? frame_bytes[4 * w + i] : 8'h00};
                            end
                            awaited_results.push_back('{st: status_after(1'b0, REQ_PARAMS),
                                pvalid: 1'b1, pidx: 4'(w), pval: word,
                                last: (w == PARAM_WORDS - 1)});
                        end
                        return;
                    end
                    bad_tails++;
                end
            end
            RX_INDEX: begin
                if (frame_fill < 1) begin
                    index_low = b;
                    frame_fill++;
                end else begin
                    block_state = {b, index_low};
                    req = REQ_BLOCK;
                    frame_fill = 0;
                    mode_now = RX_IDLE;
                end
            end
            default: begin
                mode_now = RX_IDLE;
                beep = 1'b1;
                case (b)
                    CMD_STOP: stop_state = ~stop_state;
                    CMD_TELE: tele_state = ~tele_state;
                    CMD_PARAMS: req = REQ_PARAMS;
                    CMD_FRAME: begin
                        mode_now = RX_FRAME;
                        frame_fill = 0;
                    end
                    CMD_EEPROM: req = REQ_EEPROM;
                    CMD_LOG: begin
                        if (!log_state) begin
                            log_state = 1'b1;
                            block_state = '0;
                            winfo_state = 1'b0;
                        end else begin
                            log_state = 1'b0;
                            winfo_state = 1'b1;
                        end
                    end
                    CMD_BLK_ZERO: begin
                        block_state = '0;
                        req = REQ_BLOCK;
                    end
                    CMD_BLK_DEC, CMD_BLK_INC: begin
                        beep = 1'b0;
                        if (rdy) begin
                            block_state = (b == CMD_BLK_DEC) ? block_state - 16'd1
                                                             : block_state + 16'd1;
                            req = REQ_BLOCK;
                        end
                    end
                    CMD_BLK_LOAD: begin
                        mode_now = RX_INDEX;
                        frame_fill = 0;
                    end
                    default: ;
                endcase
            end
        endcase
        awaited_results.push_back('{st: status_after(beep, req), pvalid: 1'b0, pidx: '0,
                                    pval: '0, last: 1'b1});
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic rand_ready();
        return $urandom_range(0, 3) != 0;
    endfunction

    function automatic string result_text(input t_result r);
        return {$sformatf("beep=%b stop=%b tele=%b req=%0d sd=%b wi=%b ",
                          r.st.beep, r.st.stop, r.st.tele, r.st.req, r.st.sd_save,
                          r.st.write_info),
                $sformatf("blk=%h pv=%b idx=%0d val=%h last=%b",
                          r.st.block, r.pvalid, r.pidx, r.pval, r.last)};
    endfunction

    task automatic send_rx_byte(input logic [7:0] b, input logic rdy, input logic typed,
                                input t_status typed_st);
        int idle;
        idle = pick_idle_len();
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        i_card_ready <= rdy;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        decode_rx_byte(b, rdy);
        if (typed) begin
            awaited_results[awaited_results.size() - 1] =
                '{st: typed_st, pvalid: 1'b0, pidx: '0, pval: '0, last: 1'b1};
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) sink_hold = pick_idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = {o_beep_pulse, o_stop_control, o_send_data_control, o_request,
                       o_sd_save, o_sd_write_info, o_block_number, o_param_valid,
                       o_param_index, o_param_value, o_last};
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %s", result_text(got_res));
            end else begin
                want_res = awaited_results.pop_front();
                results_checked++;
                if (got_res.st.beep !== want_res.st.beep || got_res.st.stop !== want_res.st.stop
                    || got_res.st.tele !== want_res.st.tele || got_res.st.req !== want_res.st.req
                    || got_res.st.sd_save !== want_res.st.sd_save
                    || got_res.st.write_info !== want_res.st.write_info
                    || got_res.st.block !== want_res.st.block
                    || got_res.pvalid !== want_res.pvalid || got_res.pidx !== want_res.pidx
                    || got_res.pval !== want_res.pval || got_res.last !== want_res.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on word %0d", results_checked);
                        $display("  expected %s", result_text(want_res));
                        $display("  actual   %s", result_text(got_res));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("uart_command_frame_receiver_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int         r;
        logic [7:0] b;
        t_row       row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED_ROWS[k];
            send_rx_byte(row.rx, row.rdy, row.typed,
                         '{beep: row.beep, stop: row.stop, tele: row.tele, req: row.req,
                           sd_save: row.sd, write_info: row.wi, block: row.blk});
        end
        while (bytes_sent < N_DIRECTED + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_rx_byte(CMD_FRAME, rand_ready(), 1'b0, '0);
                for (int n = 0; n < FRAME_LEN; n++) begin
                    send_rx_byte(rand_data(), rand_ready(), 1'b0, '0);
                end
                b = ($urandom_range(0, 4) == 0) ? rand_data() : TAIL_BYTE;
                send_rx_byte(b, rand_ready(), 1'b0, '0);
            end else if (r < 45) begin
                send_rx_byte(CMD_BLK_LOAD, rand_ready(), 1'b0, '0);
                send_rx_byte(rand_data(), rand_ready(), 1'b0, '0);
                send_rx_byte(rand_data(), rand_ready(), 1'b0, '0);
            end else if (r < 88) begin
                send_rx_byte(COMMANDS[$urandom_range(0, 9)], rand_ready(), 1'b0, '0);
            end else begin
                send_rx_byte(8'($urandom), rand_ready(), 1'b0, '0);
            end
            if ($urandom_range(0, 7) == 0) calm = !calm;
        end
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes (%0d directed) and checked %0d result words.",
                 bytes_sent, N_DIRECTED, results_checked);
        $display("Frames closed with a good tail: %0d, with a bad tail: %0d; mismatches: %0d.",
                 good_tails, bad_tails, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("uart_command_frame_receiver_core_tb OK");
        end else begin
            $display("uart_command_frame_receiver_core_tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
